>>> sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants for the sorted route table.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int ADDR_W   = 32;
  localparam int IFACE_W  = 4;
  localparam int NUM_W    = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 48;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_NUMBER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PROTECTED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0]  net;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  hop;
    logic [IFACE_W-1:0] iface;
    logic               direct;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    entry_t            new_entry;
    logic [NUM_W-1:0]  entry_number;
    logic [ADDR_W-1:0] lookup_addr;
  } item_t;

  typedef struct packed {
    logic                capture;
    logic                advance;
    logic                ins_write;
    logic                del_shift;
    logic                set_result;
    logic [STATUS_W-1:0] status;
    logic                hop_sel;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            full;
    logic            at_end;
    logic            bad_num;
    logic            ins_here;
    logic            lk_match;
    logic            prot;
  } sts_t;

endpackage

>>> sv/sorted_route_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_route_table_unit
// Sorted route table: insert, delete by position, first-match lookup.
// ----------------------------------------------------------------------------
// Sequencing: insert and lookup scan from accept to result, one entry compared
//   per cycle by the scan index; delete goes straight to the entry by position.
// Throughput: one item at a time; the next beat is taken once the result
//   has moved to the output register, which holds it until taken.
// Reset: synchronous rst empties the table (entry count zero); entry storage
//   itself is not cleared, so the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
module sorted_route_table_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // opcode[1:0], new_net[33:2], new_mask[65:34], new_next_hop[97:66],
  // new_iface[101:98], new_direct[102], entry_number[108:103],
  // lookup_addr[140:109], zero pad
  input  logic [srt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[2:0], found_next_hop[34:3], entry_count[40:35], zero pad
  output logic [srt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  srt_pkg::item_t item;
  srt_pkg::cmd_t  cmd;
  srt_pkg::sts_t  sts;

  always_comb begin
    item.opcode          = s_axis_tdata[1:0];
    item.new_entry.net   = s_axis_tdata[33:2];
    item.new_entry.mask  = s_axis_tdata[65:34];
    item.new_entry.hop   = s_axis_tdata[97:66];
    item.new_entry.iface = s_axis_tdata[101:98];
    item.new_entry.direct = s_axis_tdata[102];
    item.entry_number    = s_axis_tdata[108:103];
    item.lookup_addr     = s_axis_tdata[140:109];
  end

  srt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (m_axis_tdata)
  );

endmodule

>>> sv/srt_dp.sv
// ----------------------------------------------------------------------------
// srt_dp
// Route table datapath: entry registers, scan index, compare and result regs.
// ----------------------------------------------------------------------------
module srt_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  srt_pkg::item_t                    item,
  input  srt_pkg::cmd_t                     cmd,
  output srt_pkg::sts_t                     sts,
  output logic [srt_pkg::OUT_DATA_W-1:0]    out_data
);

  srt_pkg::entry_t                   entries [srt_pkg::DEPTH];
  srt_pkg::item_t                    req;
  logic [srt_pkg::CNT_W-1:0]         idx;
  logic [srt_pkg::CNT_W-1:0]         count;
  logic [srt_pkg::STATUS_W-1:0]      res_status;
  logic [srt_pkg::ADDR_W-1:0]        res_hop;
  logic [srt_pkg::OUT_DATA_W-1:0]    out_reg;
  srt_pkg::entry_t                   cur;

  assign cur = entries[idx[srt_pkg::IDX_W-1:0]];

  always_comb begin
    sts.opcode   = req.opcode;
    sts.full     = (count == srt_pkg::CNT_W'(srt_pkg::DEPTH));
    sts.at_end   = (idx == count);
    sts.bad_num  = (req.entry_number == '0) ||
                   (srt_pkg::CNT_W'(req.entry_number) > count);
    sts.ins_here = (req.new_entry.net > cur.net) ||
                   ((req.new_entry.net == cur.net) && (req.new_entry.mask > cur.mask));
    sts.lk_match = (cur.net == (req.lookup_addr & cur.mask));
    sts.prot     = cur.direct;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_write) begin
      count <= count + 1'b1;
    end else if (cmd.del_shift) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= item;
      if (item.opcode == srt_pkg::OP_DELETE) begin
        idx <= srt_pkg::CNT_W'(item.entry_number - 1'b1);
      end else begin
        idx <= '0;
      end
    end else if (cmd.advance) begin
      idx <= idx + 1'b1;
    end
    if (cmd.set_result) begin
      res_status <= cmd.status;
      res_hop    <= cmd.hop_sel ? cur.hop : '0;
    end
    if (cmd.load_out) begin
      out_reg <= srt_pkg::OUT_DATA_W'({srt_pkg::COUNT_W'(count), res_hop, res_status});
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < srt_pkg::DEPTH; k++) begin
      if (cmd.ins_write) begin
        if (k == int'(idx)) begin
          entries[k] <= req.new_entry;
        end else if (k > int'(idx)) begin
          entries[k] <= entries[(k + srt_pkg::DEPTH - 1) % srt_pkg::DEPTH];
        end
      end else if (cmd.del_shift) begin
        if ((k >= int'(idx)) && (k < srt_pkg::DEPTH - 1)) begin
          entries[k] <= entries[(k + 1) % srt_pkg::DEPTH];
        end
      end
    end
  end

  assign out_data = out_reg;

endmodule

>>> sv/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl
// Route table controller: sequences scan, insert, delete and result handoff.
// ----------------------------------------------------------------------------
module srt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  srt_pkg::sts_t sts,
  output srt_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_reg;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_valid_reg;

  always_comb begin
    cmd        = '0;
    cmd.status = srt_pkg::ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        case (sts.opcode)
          srt_pkg::OP_INSERT: begin
            if (sts.full) begin
              cmd.set_result = 1'b1;
              cmd.status     = srt_pkg::ST_FULL;
              state_next     = S_FIN;
            end else if (sts.at_end || sts.ins_here) begin
              cmd.ins_write  = 1'b1;
              cmd.set_result = 1'b1;
              state_next     = S_FIN;
            end else begin
              cmd.advance = 1'b1;
            end
          end
          srt_pkg::OP_DELETE: begin
            cmd.set_result = 1'b1;
            state_next     = S_FIN;
            if (sts.bad_num) begin
              cmd.status = srt_pkg::ST_BAD_NUMBER;
            end else if (sts.prot) begin
              cmd.status = srt_pkg::ST_PROTECTED;
            end else begin
              cmd.del_shift = 1'b1;
            end
          end
          srt_pkg::OP_LOOKUP: begin
            if (sts.at_end) begin
              cmd.set_result = 1'b1;
              cmd.status     = srt_pkg::ST_NOT_FOUND;
              state_next     = S_FIN;
            end else if (sts.lk_match) begin
              cmd.set_result = 1'b1;
              cmd.hop_sel    = 1'b1;
              state_next     = S_FIN;
            end else begin
              cmd.advance = 1'b1;
            end
          end
          default: begin
            cmd.set_result = 1'b1;
            state_next     = S_FIN;
          end
        endcase
      end
      S_FIN: begin
        if (!out_valid_reg || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid_reg <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid_reg <= 1'b1;
      end else if (out_ready) begin
        out_valid_reg <= 1'b0;
      end
    end
  end

endmodule
